// ----- sv/assert_macros.svh -----
// Assertion helpers for the checks in the top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An implication or expression that must hold at every clock edge out of reset.
`define ASSERT_HOLDS(clk, rst, label, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// An expression that must never be true at a clock edge out of reset.
`define ASSERT_NEVER(clk, rst, label, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

// ----- sv/ffac_pkg.sv -----
`timescale 1ns / 1ps

package ffac_pkg;

   // Build-time sizes of the cell store and of a handle.
   localparam int CELLS       = 128;
   localparam int HANDLE_BITS = 16;

   // Derived widths: a cell index, a count that can hold CELLS, and compare widths.
   localparam int IDX_BITS   = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_BITS   = $clog2(CELLS + 1);
   localparam int CFG_BITS   = 8;
   localparam int WIDE_BITS  = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
   localparam int FIELD_BITS = 16;
   localparam int CMP_BITS   = (HANDLE_BITS > FIELD_BITS) ? HANDLE_BITS : FIELD_BITS;

   localparam logic [CFG_BITS-1:0] MSIZE_RESET = 8'd128;

   // Operation codes.
   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_ERASE  = 2'd1;
   localparam logic [1:0] OP_DEFRAG = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_ALLOC   = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_ILLEGAL = 2'd2;

   typedef struct packed {
      logic [1:0]            operation;
      logic [CFG_BITS-1:0]   size;
      logic [FIELD_BITS-1:0] handle;
   } ffac_req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [FIELD_BITS-1:0] new_handle;
   } ffac_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       rd;
      logic       eval;
      logic       mark;
      logic       fill;
      logic       rsp;
      logic [1:0] rsp_status;
   } ffac_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       scan_done;
      logic       exhausted;
      logic       hit;
      logic       found;
      logic       mark_done;
      logic       fill_done;
   } ffac_stat_type;

endpackage

// ----- sv/first_fit_allocator_with_compaction_unit.sv -----
// Allocate reads and evaluates each cell in turn through the fitting one, then marks size cells.
// Erase scans all m cells in use; defragment scans them, then zeroes each freed cell (m: cells in use).
// A no-space allocate scans all m cells, or answers without a scan once the handles have run out.
// One item at a time; the next is taken in the first cycle with busy low, the same cycle
// in which the word is shown on rsp_valid; the receiver cannot stall.
// Synchronous reset frees every cell at once, sets the handle counter to 1 and memory_size to 128.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module first_fit_allocator_with_compaction_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  ffac_pkg::ffac_req_type        req_word,
   output logic                          rsp_valid,
   output ffac_pkg::ffac_rsp_type        rsp_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ffac_pkg::CFG_BITS-1:0] csr_data
);
   import ffac_pkg::*;

   ffac_cmd_type  cmd;
   ffac_stat_type stat;

   // Configuration is taken whenever no item is at work.
   assign csr_ready = !busy;

   ffac_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_word.operation),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   ffac_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // A result never arrives in the cycle right after an item is taken.
   `ASSERT_HOLDS(clock, reset, a_no_rsp_after_accept, (start && !busy) |=> !rsp_valid, "rsp too early")
   // The result strobe comes only once the controller is back to idle.
   `ASSERT_HOLDS(clock, reset, a_rsp_when_idle, rsp_valid |-> !busy, "rsp while busy")
   // No cell store update is commanded while idle.
   `ASSERT_NEVER(clock, reset, a_no_write_idle, !busy && (cmd.eval || cmd.mark || cmd.fill), "write while idle")
   // Failed operations carry a zero handle.
   `ASSERT_HOLDS(clock, reset, a_fail_zero_handle, (rsp_valid && rsp_word.status != ST_ALLOC) |-> (rsp_word.new_handle == '0), "handle on failure")

endmodule

// ----- sv/ffac_ctrl.sv -----
`timescale 1ns / 1ps

module ffac_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_op,
   input  ffac_pkg::ffac_stat_type stat,
   output ffac_pkg::ffac_cmd_type  cmd,
   output logic                   busy
);
   import ffac_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_CHECK = 5'b00100,
      S_MARK  = 5'b01000,
      S_FILL  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign busy = (state_ff != S_IDLE);

   // Sequencer: read a cell, evaluate it, then mark or fill as the operation needs.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_op == OP_ALLOC || req_op == OP_ERASE || req_op == OP_DEFRAG) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            if (stat.op == OP_ALLOC && stat.exhausted) begin
               cmd.rsp        = 1'b1;
               cmd.rsp_status = ST_NOSPACE;
               state_in       = S_IDLE;
            end else if (stat.scan_done) begin
               state_in = S_IDLE;
               unique case (stat.op)
                  OP_ALLOC: begin
                     cmd.rsp        = 1'b1;
                     cmd.rsp_status = ST_NOSPACE;
                  end
                  OP_ERASE: begin
                     cmd.rsp        = !stat.found;
                     cmd.rsp_status = ST_ILLEGAL;
                  end
                  OP_DEFRAG: begin
                     state_in = S_FILL;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.eval = 1'b1;
            state_in = stat.hit ? S_MARK : S_READ;
         end
         S_MARK: begin
            if (stat.mark_done) begin
               cmd.rsp        = 1'b1;
               cmd.rsp_status = ST_ALLOC;
               state_in       = S_IDLE;
            end else begin
               cmd.mark = 1'b1;
            end
         end
         S_FILL: begin
            if (stat.fill_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.fill = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/ffac_dpath.sv -----
`timescale 1ns / 1ps

module ffac_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  ffac_pkg::ffac_req_type          req_word,
   input  ffac_pkg::ffac_cmd_type          cmd,
   input  logic                            csr_write,
   input  logic [ffac_pkg::CFG_BITS-1:0]   csr_data,
   output ffac_pkg::ffac_stat_type         stat,
   output logic                            rsp_valid,
   output ffac_pkg::ffac_rsp_type          rsp_word
);
   import ffac_pkg::*;

   // Cell store with one valid bit per cell; a cell never written reads as free.
   logic [HANDLE_BITS-1:0] owner_mem_ff [CELLS];
   logic [CELLS-1:0]       valid_ff;
   logic [HANDLE_BITS-1:0] rd_data_ff;
   logic                   rd_valid_ff;

   logic [CFG_BITS-1:0]    msize_ff;
   logic [HANDLE_BITS-1:0] next_handle_ff, next_handle_in;
   logic [1:0]             op_ff;
   logic [CFG_BITS-1:0]    size_ff;
   logic [FIELD_BITS-1:0]  handle_ff;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic [CNT_BITS-1:0]    dst_ff, dst_in;
   logic [CNT_BITS-1:0]    run_len_ff, run_len_in;
   logic [IDX_BITS-1:0]    run_start_ff, run_start_in;
   logic [CNT_BITS-1:0]    wr_cnt_ff, wr_cnt_in;
   logic                   found_ff, found_in;
   logic                   rsp_valid_ff;
   ffac_rsp_type           rsp_word_ff;

   logic [CNT_BITS-1:0]    cells_used;
   logic [HANDLE_BITS-1:0] owner;
   logic                   cell_free;
   logic                   match;
   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_addr;
   logic [HANDLE_BITS-1:0] wr_data;

   // Number of cells in use, clamped to the built cell count.
   assign cells_used = (WIDE_BITS'(msize_ff) < WIDE_BITS'(CELLS)) ?
                       CNT_BITS'(msize_ff) : CNT_BITS'(CELLS);

   assign owner     = rd_valid_ff ? rd_data_ff : '0;
   assign cell_free = (owner == '0);
   assign match     = (handle_ff != '0) && (CMP_BITS'(owner) == CMP_BITS'(handle_ff));

   // Status toward the controller.
   always_comb begin
      stat.op        = op_ff;
      stat.scan_done = (idx_ff == cells_used);
      stat.exhausted = (next_handle_ff == '0);
      stat.hit       = (op_ff == OP_ALLOC) && cell_free &&
                       ((WIDE_BITS'(run_len_ff) + WIDE_BITS'(1)) >= WIDE_BITS'(size_ff));
      stat.found     = found_ff;
      stat.mark_done = (WIDE_BITS'(wr_cnt_ff) == WIDE_BITS'(size_ff));
      stat.fill_done = (dst_ff == cells_used);
   end

   // Write port select: erase clears, defragment moves down, allocate marks, fill zeroes.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[IDX_BITS-1:0];
      wr_data = '0;
      if (cmd.eval) begin
         case (op_ff)
            OP_ERASE: begin
               wr_en = match;
            end
            OP_DEFRAG: begin
               wr_en   = !cell_free;
               wr_addr = dst_ff[IDX_BITS-1:0];
               wr_data = owner;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
      if (cmd.mark) begin
         wr_en   = 1'b1;
         wr_addr = run_start_ff + wr_cnt_ff[IDX_BITS-1:0];
         wr_data = next_handle_ff;
      end
      if (cmd.fill) begin
         wr_en   = 1'b1;
         wr_addr = dst_ff[IDX_BITS-1:0];
         wr_data = '0;
      end
   end

   // Next values of the scan counters and flags.
   always_comb begin
      idx_in         = idx_ff;
      dst_in         = dst_ff;
      run_len_in     = run_len_ff;
      run_start_in   = run_start_ff;
      wr_cnt_in      = wr_cnt_ff;
      found_in       = found_ff;
      next_handle_in = next_handle_ff;
      if (cmd.load) begin
         idx_in     = '0;
         dst_in     = '0;
         run_len_in = '0;
         wr_cnt_in  = '0;
         found_in   = 1'b0;
      end
      if (cmd.eval) begin
         idx_in = idx_ff + 1'b1;
         case (op_ff)
            OP_ALLOC: begin
               if (cell_free) begin
                  run_len_in = run_len_ff + 1'b1;
                  if (run_len_ff == '0) begin
                     run_start_in = idx_ff[IDX_BITS-1:0];
                  end
               end else begin
                  run_len_in = '0;
               end
            end
            OP_ERASE: begin
               if (match) begin
                  found_in = 1'b1;
               end
            end
            OP_DEFRAG: begin
               if (!cell_free) begin
                  dst_in = dst_ff + 1'b1;
               end
            end
            default: begin
               idx_in = idx_ff + 1'b1;
            end
         endcase
      end
      if (cmd.mark) begin
         wr_cnt_in = wr_cnt_ff + 1'b1;
      end
      if (cmd.fill) begin
         dst_in = dst_ff + 1'b1;
      end
      // The counter wraps to zero after the last handle and then stays there.
      if (cmd.rsp && cmd.rsp_status == ST_ALLOC) begin
         next_handle_in = next_handle_ff + 1'b1;
      end
   end

   // Memory array and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         owner_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= owner_mem_ff[idx_ff[IDX_BITS-1:0]];
      end
   end

   // Valid bits: reset frees every cell at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.rd) begin
            rd_valid_ff <= valid_ff[idx_ff[IDX_BITS-1:0]];
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         msize_ff       <= MSIZE_RESET;
         next_handle_ff <= HANDLE_BITS'(1);
         rsp_valid_ff   <= 1'b0;
         idx_ff         <= '0;
         dst_ff         <= '0;
         run_len_ff     <= '0;
         wr_cnt_ff      <= '0;
         found_ff       <= 1'b0;
      end else begin
         if (csr_write) begin
            msize_ff <= csr_data;
         end
         next_handle_ff <= next_handle_in;
         rsp_valid_ff   <= cmd.rsp;
         idx_ff         <= idx_in;
         dst_ff         <= dst_in;
         run_len_ff     <= run_len_in;
         wr_cnt_ff      <= wr_cnt_in;
         found_ff       <= found_in;
      end
   end

   // Latched request fields, run start and result word.
   always_ff @(posedge clock) begin
      run_start_ff <= run_start_in;
      if (cmd.load) begin
         op_ff     <= req_word.operation;
         size_ff   <= req_word.size;
         handle_ff <= req_word.handle;
      end
      if (cmd.rsp) begin
         rsp_word_ff.status     <= cmd.rsp_status;
         rsp_word_ff.new_handle <= (cmd.rsp_status == ST_ALLOC) ?
                                   CMP_BITS'(next_handle_ff) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- tb/sv/ffac_reply_check.sv -----
`timescale 1ns / 1ps

// Watches the request, reply and register channels of the allocator, keeps a
// copy of the cell store, and compares each reply word with the oldest one due.
module ffac_reply_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  ffac_pkg::ffac_req_type        req_word,
   input  logic                          rsp_valid,
   input  ffac_pkg::ffac_rsp_type        rsp_word,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [ffac_pkg::CFG_BITS-1:0] csr_data,
   output int                            outstanding,
   output int                            mismatches
);
   import ffac_pkg::*;

   // Shadow of the cell store, the handle counter and the size register.
   logic [HANDLE_BITS-1:0] owner_of [CELLS];
   logic [HANDLE_BITS-1:0] issue_handle;
   logic [CFG_BITS-1:0]    cells_cfg;
   ffac_rsp_type           due_replies [$];
   int                     miss_count = 0;

   // Applies one request word to the shadow store. Returns 1 when the request
   // produces a reply word, which is then placed in reply.
   function automatic bit apply_cell_op(input ffac_req_type rq, output ffac_rsp_type reply);
      int  span;
      int  pos;
      int  dst;
      int  run_start;
      int  run_len;
      int  want_len;
      int  j;
      bit  placed;
      bit  hit;
      reply.status     = ST_NOSPACE;
      reply.new_handle = '0;
      span     = (cells_cfg < CELLS) ? int'(cells_cfg) : CELLS;
      want_len = int'(rq.size);
      case (rq.operation)
         OP_ALLOC: begin
            // First fit: measure each free run from the bottom and take the first
            // that is long enough. A used-up handle counter never fits.
            placed = 1'b0;
            pos    = 0;
            if (issue_handle != '0) begin
               while (pos < span && !placed) begin
                  if (owner_of[pos] != '0) begin
                     pos++;
                  end else begin
                     run_start = pos;
                     run_len   = 0;
                     while (pos < span && owner_of[pos] == '0) begin
                        run_len++;
                        pos++;
                     end
                     if (run_len >= want_len) begin
                        for (j = run_start; j < run_start + want_len; j++)
                           owner_of[j] = issue_handle;
                        reply.status     = ST_ALLOC;
                        reply.new_handle = FIELD_BITS'(issue_handle);
                        issue_handle = (issue_handle == {HANDLE_BITS{1'b1}}) ?
                                       '0 : issue_handle + 1'b1;
                        placed = 1'b1;
                     end
                  end
               end
            end
            return 1'b1;
         end
         OP_ERASE: begin
            // Free every cell in use that carries the handle.
            hit = 1'b0;
            if (rq.handle != '0) begin
               for (pos = 0; pos < span; pos++) begin
                  if (CMP_BITS'(owner_of[pos]) == CMP_BITS'(rq.handle)) begin
                     owner_of[pos] = '0;
                     hit = 1'b1;
                  end
               end
            end
            if (hit)
               return 1'b0;
            reply.status = ST_ILLEGAL;
            return 1'b1;
         end
         OP_DEFRAG: begin
            // Slide owned cells down in order and clear the rest of the range.
            dst = 0;
            for (pos = 0; pos < span; pos++) begin
               if (owner_of[pos] != '0) begin
                  owner_of[dst] = owner_of[pos];
                  dst++;
               end
            end
            for (pos = dst; pos < span; pos++)
               owner_of[pos] = '0;
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Sample every channel at the clock edge, in the order register, request, reply.
   always @(posedge clock) begin : watch
      ffac_rsp_type reply;
      ffac_rsp_type want;
      int           i;
      if (reset) begin
         for (i = 0; i < CELLS; i++)
            owner_of[i] = '0;
         issue_handle = HANDLE_BITS'(1);
         cells_cfg    = MSIZE_RESET;
         due_replies.delete();
      end else begin
         if (csr_valid && csr_ready)
            cells_cfg = csr_data;
         if (start && !busy) begin
            if (apply_cell_op(req_word, reply))
               due_replies = {due_replies, reply};
         end
         if (rsp_valid) begin
            if (due_replies.size() == 0) begin
               $display("%0t: reply word with none due, got status %0d handle %0d",
                        $time, rsp_word.status, rsp_word.new_handle);
               miss_count++;
            end else begin
               want = due_replies.pop_front();
               if (rsp_word.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_word.status);
                  miss_count++;
               end
               if (rsp_word.new_handle !== want.new_handle) begin
                  $display("%0t: new_handle expected %0d, got %0d",
                           $time, want.new_handle, rsp_word.new_handle);
                  miss_count++;
               end
            end
         end
      end
      outstanding <= due_replies.size();
      mismatches  <= miss_count;
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import ffac_pkg::*;

   localparam logic [1:0]            OP_UNUSED     = 2'd3;
   localparam int                    SETTLE_CYCLES = 450;
   localparam int                    DRAIN_LIMIT   = 4000;
   localparam int                    PHASE_ITEMS   = 150;
   localparam longint                RUN_LIMIT_NS  = 30_000_000;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   ffac_req_type          req_word  = '0;
   logic                  rsp_valid;
   ffac_rsp_type          rsp_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_BITS-1:0]   csr_data  = '0;
   int                    outstanding;
   int                    mismatches;

   // Handles seen in granted replies, used to aim erase words at live blocks.
   logic [FIELD_BITS-1:0] roster [$];
   logic [FIELD_BITS-1:0] top_handle = '0;
   logic [CFG_BITS-1:0]   cells_now  = MSIZE_RESET;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   first_fit_allocator_with_compaction_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   ffac_reply_check u_reply_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   // Record every granted handle for the stimulus.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_word.status == ST_ALLOC) begin
         roster = {roster, rsp_word.new_handle};
         top_handle <= rsp_word.new_handle;
      end
   end

   // Mostly back to back, sometimes a short gap, now and then a long pause.
   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // Small sizes dominate; some reach the whole range, some are zero or oversized.
   function automatic int pick_size(int span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return 0;
      if (r < 10)
         return $urandom_range(0, 255);
      if (r < 22)
         return $urandom_range(1, span);
      return $urandom_range(1, (span < 6) ? span : 6);
   endfunction

   // Present one request word and hold it until the block takes it.
   task automatic issue(logic [1:0] op, int sz, logic [FIELD_BITS-1:0] h, bit quiet);
      int gap;
      gap = pick_gap(quiet);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= '{operation: op, size: CFG_BITS'(sz), handle: h};
      do @(posedge clock); while (busy);
   endtask

   // Erase a handle; with the whole store in use the erase clears it for good.
   task automatic erase_handle(logic [FIELD_BITS-1:0] h, bit quiet);
      int k;
      issue(OP_ERASE, $urandom_range(0, 255), h, quiet);
      if (cells_now >= CELLS) begin
         for (k = roster.size() - 1; k >= 0; k--)
            if (roster[k] == h)
               roster.delete(k);
      end
   endtask

   // Wait for every reply word, then long enough for a silent erase or compaction.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_cells(logic [CFG_BITS-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cells_now = v;
   endtask

   // One phase of random traffic at the current size setting.
   task automatic run_phase(int count);
      bit                    quiet;
      int                    r;
      int                    span;
      logic [FIELD_BITS-1:0] h;
      quiet = ($urandom_range(0, 3) == 0);
      span  = (cells_now < CELLS) ? int'(cells_now) : CELLS;
      if (span < 1)
         span = 1;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            issue(OP_ALLOC, pick_size(span), FIELD_BITS'($urandom_range(0, 65535)), quiet);
         end else if (r < 80) begin
            if (roster.size() > 0 && $urandom_range(0, 99) < 85) begin
               h = roster[$urandom_range(0, roster.size() - 1)];
            end else begin
               case ($urandom_range(0, 2))
                  0:       h = '0;
                  1:       h = FIELD_BITS'($urandom_range(0, 65535));
                  default: h = top_handle + 1'b1;
               endcase
            end
            erase_handle(h, quiet);
         end else if (r < 96) begin
            issue(OP_DEFRAG, $urandom_range(0, 255), FIELD_BITS'($urandom_range(0, 65535)),
                  quiet);
         end else if (r < 98) begin
            issue(OP_UNUSED, $urandom_range(0, 255), FIELD_BITS'($urandom_range(0, 65535)),
                  quiet);
         end else begin
            // Hold off until every reply word has come back.
            start <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
      end
   endtask

   initial begin
      int                    sweep [11] = '{128, 1, 0, 255, 7, -1, -1, 64, -1, -1, 128};
      int                    p;
      int                    drain;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero size, full store, no space, bad erases, holes and compaction.
      issue(OP_ALLOC, 0, '0, 1'b0);
      issue(OP_ALLOC, CELLS, '0, 1'b0);
      issue(OP_ALLOC, 1, '0, 1'b0);
      issue(OP_ALLOC, 0, '1, 1'b0);
      erase_handle('0, 1'b0);
      erase_handle(16'd1, 1'b0);
      erase_handle('1, 1'b0);
      erase_handle(16'd2, 1'b0);
      issue(OP_ALLOC, 255, '0, 1'b0);
      issue(OP_ALLOC, CELLS + 1, '0, 1'b0);
      issue(OP_ALLOC, 3, '0, 1'b0);
      issue(OP_ALLOC, 5, '0, 1'b0);
      issue(OP_ALLOC, 2, '0, 1'b0);
      erase_handle(16'd4, 1'b0);
      issue(OP_ALLOC, 6, '0, 1'b0);
      issue(OP_ALLOC, 5, '0, 1'b0);
      erase_handle(16'd3, 1'b0);
      issue(OP_UNUSED, 255, '1, 1'b0);
      issue(OP_DEFRAG, 0, '0, 1'b0);
      issue(OP_ALLOC, CELLS - 13, '0, 1'b0);
      issue(OP_ALLOC, 0, '0, 1'b0);
      erase_handle(16'd5, 1'b0);
      issue(OP_DEFRAG, 255, '1, 1'b0);
      erase_handle(16'd5, 1'b0);
      settle();

      // Random phases over a sweep of size settings, extremes included.
      for (p = 0; p < 11; p++) begin
         write_cells((sweep[p] < 0) ? CFG_BITS'($urandom_range(2, 127)) : CFG_BITS'(sweep[p]));
         run_phase(PHASE_ITEMS);
         settle();
      end

      // Shrink the store to one cell and finish with a few corner words there.
      write_cells(CFG_BITS'(1));
      issue(OP_ALLOC, 0, '0, 1'b0);
      issue(OP_ALLOC, 1, '0, 1'b0);
      issue(OP_ERASE, 0, top_handle, 1'b0);
      issue(OP_DEFRAG, 0, '0, 1'b0);
      issue(OP_ALLOC, 0, '0, 1'b0);

      // Drain the remaining reply words and give the verdict.
      start <= 1'b0;
      drain = 0;
      do begin
         @(posedge clock);
         drain++;
      end while (outstanding != 0 && drain < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("first_fit_allocator_with_compaction_unit regression: pass");
      else
         $display("first_fit_allocator_with_compaction_unit regression: fail");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(RUN_LIMIT_NS);
      $display("first_fit_allocator_with_compaction_unit regression: fail");
      $finish;
   end

endmodule
